/* hw/rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros shared by the checker files.
// Each macro expects clk and arst_n in scope.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle
`define AST_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Antecedent implies a delayed consequent
`define AST_LAT2(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##2 (cons)) \
		else $error("two-cycle latency check failed");

`endif

/* hw/rtl/umd_pkg.sv */
// ---------------------------------------------------------------------------
// umd_pkg
// Types and opcode constants for the unaligned move decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package umd_pkg;

	// Opcode groups, instruction bits 15:12
	localparam logic [3:0] GRP_IDX     = 4'h0;  // indexed store / load
	localparam logic [3:0] GRP_ST_DISP = 4'h1;  // store long with displacement
	localparam logic [3:0] GRP_ST_PTR  = 4'h2;  // store via pointer, pre-decrement when bit 2 is set
	localparam logic [3:0] GRP_LD_DISP = 4'h5;  // load long with displacement
	localparam logic [3:0] GRP_LD_PTR  = 4'h6;  // load via pointer, post-increment when bit 2 is set
	localparam logic [3:0] GRP_WORD_R0 = 4'h8;  // word moves through R0
	localparam logic [3:0] GRP_PC_WORD = 4'h9;  // PC-relative word load
	localparam logic [3:0] GRP_PC_LONG = 4'hD;  // PC-relative long load

	// Sub-codes of the R0 word group, instruction bits 11:8
	localparam logic [3:0] SUB_STW_DISP = 4'h1;
	localparam logic [3:0] SUB_LDW_DISP = 4'h5;

	// Size codes, instruction bits 1:0
	localparam logic [1:0] SZ_LONG = 2'd2;
	localparam logic [1:0] SZ_BAD  = 2'd3;

	// Access sizes in bytes
	localparam logic [2:0] BYTES_WORD = 3'd2;
	localparam logic [2:0] BYTES_LONG = 3'd4;

	// Status codes
	localparam logic STAT_OK    = 1'b0;
	localparam logic STAT_UNSUP = 1'b1;

	// Input beat
	typedef struct packed {
		logic [15:0] instruction;
		logic [31:0] reg_m_value;
		logic [31:0] reg_n_value;
		logic [31:0] reg_zero_value;
		logic [31:0] pc_value;
	} umd_req_t;

	// Result beat
	typedef struct packed {
		logic        status;
		logic        is_store;
		logic [31:0] mem_address;
		logic [2:0]  size_bytes;
		logic        load_signed;
		logic [3:0]  data_reg;
		logic [31:0] store_data;
		logic        writeback_valid;
		logic [3:0]  writeback_reg;
		logic [31:0] writeback_value;
		logic [31:0] next_pc;
	} umd_result_t;

endpackage

`default_nettype wire

/* hw/rtl/umd_decode.sv */
// ---------------------------------------------------------------------------
// umd_decode
// Combinational decode of one faulting move instruction into a memory
// request, pointer write-back and next PC.
// ---------------------------------------------------------------------------
`default_nettype none

module umd_decode (
	input  wire umd_pkg::umd_req_t req,
	output umd_pkg::umd_result_t   res
);
	import umd_pkg::*;

	logic [3:0]  grp;
	logic [3:0]  rn;
	logic [3:0]  rm;
	logic [3:0]  d4;
	logic [7:0]  d8;
	logic [1:0]  szc;
	logic [2:0]  sz;
	logic [31:0] sz32;
	logic        ok;
	logic        predec;
	logic [31:0] base;
	logic [31:0] offs;
	logic [31:0] addr_sum;
	logic [31:0] postinc_sum;
	logic [31:0] pc_plus2;
	umd_result_t raw;

	// Split the instruction word
	assign grp  = req.instruction[15:12];
	assign rn   = req.instruction[11:8];
	assign rm   = req.instruction[7:4];
	assign d4   = req.instruction[3:0];
	assign d8   = req.instruction[7:0];
	assign szc  = req.instruction[1:0];
	assign sz   = 3'b001 << szc;
	assign sz32 = {29'd0, sz};

	// Pick the address operands and the plain request fields
	always_comb begin
		raw    = '0;
		ok     = 1'b1;
		predec = 1'b0;
		base   = '0;
		offs   = '0;
		unique case (grp)
			GRP_IDX: begin
				if (szc == SZ_BAD) begin
					ok = 1'b0;
				end else begin
					raw.size_bytes = sz;
					offs           = req.reg_zero_value;
					if (req.instruction[3]) begin
						base            = req.reg_m_value;
						raw.data_reg    = rn;
						raw.load_signed = (szc != SZ_LONG);
					end else begin
						raw.is_store   = 1'b1;
						base           = req.reg_n_value;
						raw.data_reg   = rm;
						raw.store_data = req.reg_m_value;
					end
				end
			end
			GRP_ST_DISP: begin
				raw.is_store   = 1'b1;
				raw.size_bytes = BYTES_LONG;
				base           = req.reg_n_value;
				offs           = {26'd0, d4, 2'b00};
				raw.data_reg   = rm;
				raw.store_data = req.reg_m_value;
			end
			GRP_ST_PTR: begin
				if (szc == SZ_BAD) begin
					ok = 1'b0;
				end else begin
					raw.is_store   = 1'b1;
					raw.size_bytes = sz;
					base           = req.reg_n_value;
					raw.data_reg   = rm;
					raw.store_data = req.reg_m_value;
					if (req.instruction[2]) begin
						predec            = 1'b1;
						offs              = ~sz32 + 32'd1;
						raw.writeback_valid = 1'b1;
						raw.writeback_reg = rn;
					end
				end
			end
			GRP_LD_DISP: begin
				raw.size_bytes = BYTES_LONG;
				base           = req.reg_m_value;
				offs           = {26'd0, d4, 2'b00};
				raw.data_reg   = rn;
			end
			GRP_LD_PTR: begin
				if (szc == SZ_BAD) begin
					ok = 1'b0;
				end else begin
					raw.size_bytes  = sz;
					base            = req.reg_m_value;
					raw.data_reg    = rn;
					raw.load_signed = (szc != SZ_LONG);
					if (req.instruction[2]) begin
						raw.writeback_valid = 1'b1;
						raw.writeback_reg   = rm;
						raw.writeback_value = postinc_sum;
					end
				end
			end
			GRP_WORD_R0: begin
				base = req.reg_m_value;
				offs = {27'd0, d4, 1'b0};
				if (rn == SUB_STW_DISP) begin
					raw.is_store   = 1'b1;
					raw.size_bytes = BYTES_WORD;
					raw.store_data = req.reg_zero_value;
				end else if (rn == SUB_LDW_DISP) begin
					raw.size_bytes  = BYTES_WORD;
					raw.load_signed = 1'b1;
				end else begin
					ok = 1'b0;
				end
			end
			GRP_PC_WORD: begin
				raw.size_bytes  = BYTES_WORD;
				base            = req.pc_value;
				offs            = {23'd0, d8, 1'b0} + 32'd4;
				raw.data_reg    = rn;
				raw.load_signed = 1'b1;
			end
			GRP_PC_LONG: begin
				raw.size_bytes = BYTES_LONG;
				base           = {req.pc_value[31:2], 2'b00};
				offs           = {22'd0, d8, 2'b00} + 32'd4;
				raw.data_reg   = rn;
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	// One address adder, one post-increment adder, one PC adder
	assign addr_sum    = base + offs;
	assign postinc_sum = req.reg_m_value + sz32;
	assign pc_plus2    = req.pc_value + 32'd2;

	// Merge the sum into the result; drop everything for unsupported codes
	always_comb begin
		res = raw;
		res.mem_address = addr_sum;
		res.next_pc     = pc_plus2;
		if (predec) begin
			res.writeback_value = addr_sum;
			if (rm == rn) begin
				res.store_data = addr_sum;
			end
		end
		if (!ok) begin
			res        = '0;
			res.status = STAT_UNSUP;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/unaligned_move_decoder_unit.sv */
// ---------------------------------------------------------------------------
// unaligned_move_decoder_unit
// Decodes a faulting unaligned move into a memory request, pointer
// write-back and next PC.
// ---------------------------------------------------------------------------
//  channel   handshake            payload
//  request   start / busy         instruction, reg_m/n/zero_value, pc_value
//  result    done (one cycle)     status .. next_pc
//
//  One instruction is taken per cycle; busy stays low.
//  The request is captured in the input register; done comes from the result register.
//  The input register and the result register bound a single decode stage
//  with one address adder.
//  arst_n clears the valid bits; payload registers are not reset.
//  The receiver cannot stall; every result is shown for exactly one cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module unaligned_move_decoder_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [15:0] instruction,
	input  wire logic [31:0] reg_m_value,
	input  wire logic [31:0] reg_n_value,
	input  wire logic [31:0] reg_zero_value,
	input  wire logic [31:0] pc_value,
	output logic             done,
	output logic             status,
	output logic             is_store,
	output logic [31:0]      mem_address,
	output logic [2:0]       size_bytes,
	output logic             load_signed,
	output logic [3:0]       data_reg,
	output logic [31:0]      store_data,
	output logic             writeback_valid,
	output logic [3:0]       writeback_reg,
	output logic [31:0]      writeback_value,
	output logic [31:0]      next_pc
);
	import umd_pkg::*;

	logic        valid_s1;
	umd_req_t    req_s1;
	logic        valid_s2;
	umd_result_t res_s2;
	umd_result_t res_d;

	// Never stall the requester
	assign busy = 1'b0;

	// Capture the request beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= '{instruction:    instruction,
			            reg_m_value:    reg_m_value,
			            reg_n_value:    reg_n_value,
			            reg_zero_value: reg_zero_value,
			            pc_value:       pc_value};
		end
	end

	// Decode
	umd_decode u_decode (
		.req (req_s1),
		.res (res_d)
	);

	// Register the result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			res_s2 <= res_d;
		end
	end

	// Drive the result ports
	assign done            = valid_s2;
	assign status          = res_s2.status;
	assign is_store        = res_s2.is_store;
	assign mem_address     = res_s2.mem_address;
	assign size_bytes      = res_s2.size_bytes;
	assign load_signed     = res_s2.load_signed;
	assign data_reg        = res_s2.data_reg;
	assign store_data      = res_s2.store_data;
	assign writeback_valid = res_s2.writeback_valid;
	assign writeback_reg   = res_s2.writeback_reg;
	assign writeback_value = res_s2.writeback_value;
	assign next_pc         = res_s2.next_pc;

endmodule

`default_nettype wire

/* hw/rtl/umd_checker.sv */
// ---------------------------------------------------------------------------
// umd_checker
// Port-level checks for the unaligned move decoder, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module umd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic        status,
	input wire logic        is_store,
	input wire logic [2:0]  size_bytes,
	input wire logic        writeback_valid,
	input wire logic [31:0] next_pc
);

	// Every accepted beat yields a result through the input and result registers
	`AST_LAT2(a_latency, start && !busy, done)

	// No result appears without an accepted beat behind it
	`AST_SAME(a_no_spurious, done, $past(start, 2) && !$past(busy, 2))

	// Unsupported results carry nothing else
	`AST_SAME(a_unsup_clear, done && status, !is_store && size_bytes == 3'd0 && !writeback_valid)
	`AST_SAME(a_unsup_pc, done && status, next_pc == 32'd0)

	// Handled results name a legal access size
	`AST_SAME(a_size_legal, done && !status, size_bytes == 3'd1 || size_bytes == 3'd2 || size_bytes == 3'd4)

endmodule

bind unaligned_move_decoder_unit umd_checker u_umd_checker (.*);

`default_nettype wire
